### hw/rtl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// Record table deframer package
// Shared constants, status codes and result types of the record table deframer.
// ----------------------------------------------------------------------------
package rtd_pkg;

    localparam int ENTRY_LIMIT      = 1024;
    localparam int HDR_BYTES        = 8;
    localparam int ENTRY_BYTES      = 25;
    localparam int ENTRY_DATA_BYTES = ENTRY_BYTES - 1;
    localparam int HDR_KEEP_W       = (HDR_BYTES - 1) * 8;
    localparam int ENTRY_DATA_W     = ENTRY_DATA_BYTES * 8;
    localparam int SCHEMA_W         = 32;
    localparam int HDR_COUNT_W      = 32;
    localparam int CNT_W            = $clog2(ENTRY_LIMIT + 1);
    localparam int POS_W            = $clog2(HDR_BYTES + 1);
    localparam int EBI_W            = $clog2(ENTRY_BYTES);
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int FIFO_SUM_W       = FIFO_CNT_W + 1;

    localparam logic [SCHEMA_W-1:0] SCHEMA_RESET = 32'd1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SHORT  = 2'd1;
    localparam logic [1:0] ST_FORMAT = 2'd2;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic               result_kind;
        logic [63:0]        entity_id;
        logic signed [63:0] current_value;
        logic signed [63:0] maximum_value;
        logic               alive_flag;
        logic [1:0]         status;
        logic               last_result;
    } rtd_result_t;

    typedef struct packed {
        logic [1:0]  num;
        rtd_result_t res0;
        rtd_result_t res1;
    } rtd_push_t;

endpackage

### hw/rtl/rtd_byte_if.sv
// ----------------------------------------------------------------------------
// Message byte channel
// Valid/ready channel that carries one message byte and its end marker.
// ----------------------------------------------------------------------------
interface rtd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

### hw/rtl/rtd_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one decoded entry or one final status.
// ----------------------------------------------------------------------------
interface rtd_result_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [63:0]        entity_id;
    logic signed [63:0] current_value;
    logic signed [63:0] maximum_value;
    logic               alive_flag;
    logic [1:0]         status;
    logic               last_result;

    modport source (
        output valid, output result_kind, output entity_id, output current_value,
        output maximum_value, output alive_flag, output status, output last_result,
        input ready
    );
    modport sink (
        input valid, input result_kind, input entity_id, input current_value,
        input maximum_value, input alive_flag, input status, input last_result,
        output ready
    );
endinterface

### hw/rtl/rtd_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries the expected schema word.
// ----------------------------------------------------------------------------
interface rtd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] schema_word;

    modport source (output valid, output schema_word, input ready);
    modport sink (input valid, input schema_word, output ready);
endinterface

### hw/rtl/record_table_deframer_core.sv
// A taken byte is held in the decoder's input register, and its results are written from there into the result queue.
// Throughput: one byte per cycle; a byte gives at most two results, held in a
// four-deep result queue, and input stalls while the queued results and those
// of the byte being decoded number more than two.
// Reset clears the message position, counts and error flag and empties the queue; the schema word is 1.
// ----------------------------------------------------------------------------
// Record table deframer core
// Top level: schema register, byte decoder and result queue.
// ----------------------------------------------------------------------------
module record_table_deframer_core (
    input  logic                clk,
    input  logic                rst_n,
    rtd_byte_if.sink            msg,
    rtd_result_if.source        res,
    rtd_cfg_if.sink             cfg
);
    import rtd_pkg::*;

    logic [SCHEMA_W-1:0]   schema_reg;
    rtd_push_t             push;
    rtd_result_t           head;
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] level;
    logic [FIFO_SUM_W-1:0] pending;
    logic                  take;
    logic                  pop;

    assign pending   = FIFO_SUM_W'(level) + FIFO_SUM_W'(push.num);
    assign msg.ready = pending <= FIFO_SUM_W'(FIFO_DEPTH - 2);
    assign take      = msg.valid & msg.ready;
    assign cfg.ready = 1'b1;
    assign pop       = res.valid & res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            schema_reg <= SCHEMA_RESET;
        end
        else if (cfg.valid)
        begin
            schema_reg <= cfg.schema_word;
        end
    end

    rtd_decoder u_decoder (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .data_byte      (msg.data_byte),
        .end_of_message (msg.end_of_message),
        .schema_word    (schema_reg),
        .push           (push)
    );

    rtd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .level     (level)
    );

    assign res.valid         = not_empty;
    assign res.result_kind   = head.result_kind;
    assign res.entity_id     = head.entity_id;
    assign res.current_value = head.current_value;
    assign res.maximum_value = head.maximum_value;
    assign res.alive_flag    = head.alive_flag;
    assign res.status        = head.status;
    assign res.last_result   = head.last_result;

endmodule

### hw/rtl/rtd_decoder.sv
// ----------------------------------------------------------------------------
// Record table decoder
// Input register, message state and the per-byte decode that yields up to two
// results for each byte.
// ----------------------------------------------------------------------------
module rtd_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  logic [7:0]                        data_byte,
    input  logic                              end_of_message,
    input  logic [rtd_pkg::SCHEMA_W-1:0]      schema_word,
    output rtd_pkg::rtd_push_t                push
);
    import rtd_pkg::*;

    logic                    item_vld_reg;
    logic [7:0]              byte_reg;
    logic                    eom_reg;

    logic [POS_W-1:0]        pos_reg,  pos_next;
    logic [HDR_KEEP_W-1:0]   hdr_reg,  hdr_next;
    logic [CNT_W-1:0]        cnt_reg,  cnt_next;
    logic [CNT_W-1:0]        seen_reg, seen_next;
    logic [EBI_W-1:0]        ebi_reg,  ebi_next;
    logic                    err_reg,  err_next;
    logic [ENTRY_DATA_W-1:0] ent_reg,  ent_next;

    logic [HDR_COUNT_W-1:0]  hdr_count;
    logic                    emit;
    logic [1:0]              st;
    rtd_result_t             entry_res;
    rtd_result_t             status_res;

    assign hdr_count = {byte_reg, hdr_reg[HDR_KEEP_W-1:SCHEMA_W]};

    always_comb
    begin
        pos_next  = pos_reg;
        hdr_next  = hdr_reg;
        cnt_next  = cnt_reg;
        seen_next = seen_reg;
        ebi_next  = ebi_reg;
        err_next  = err_reg;
        ent_next  = ent_reg;
        emit      = 1'b0;
        st        = ST_OK;

        if (pos_reg < POS_W'(HDR_BYTES))
        begin
            hdr_next = {byte_reg, hdr_reg[HDR_KEEP_W-1:8]};
            if (pos_reg == POS_W'(HDR_BYTES - 1))
            begin
                cnt_next = hdr_count[CNT_W-1:0];
                if (hdr_reg[SCHEMA_W-1:0] != schema_word
                    || hdr_count > HDR_COUNT_W'(ENTRY_LIMIT))
                begin
                    err_next = 1'b1;
                end
            end
        end
        else if (seen_reg >= cnt_reg)
        begin
            err_next = 1'b1;
        end
        else if (ebi_reg < EBI_W'(ENTRY_DATA_BYTES))
        begin
            ent_next = {byte_reg, ent_reg[ENTRY_DATA_W-1:8]};
            ebi_next = ebi_reg + EBI_W'(1);
        end
        else
        begin
            if (byte_reg > 8'd1)
            begin
                err_next = 1'b1;
            end
            emit      = ~err_next;
            ebi_next  = '0;
            seen_next = seen_reg + CNT_W'(1);
        end

        if (pos_reg < POS_W'(HDR_BYTES))
        begin
            pos_next = pos_reg + POS_W'(1);
        end

        if (pos_next < POS_W'(HDR_BYTES))
        begin
            st = ST_SHORT;
        end
        else if (err_next || ebi_next != '0 || seen_next != cnt_next)
        begin
            st = ST_FORMAT;
        end

        if (eom_reg)
        begin
            pos_next  = '0;
            cnt_next  = '0;
            seen_next = '0;
            ebi_next  = '0;
            err_next  = 1'b0;
        end
    end

    always_comb
    begin
        entry_res               = '0;
        entry_res.result_kind   = KIND_ENTRY;
        entry_res.entity_id     = ent_reg[63:0];
        entry_res.current_value = ent_reg[127:64];
        entry_res.maximum_value = ent_reg[191:128];
        entry_res.alive_flag    = byte_reg[0];

        status_res             = '0;
        status_res.result_kind = KIND_STATUS;
        status_res.status      = st;
        status_res.last_result = 1'b1;

        push      = '0;
        push.res0 = emit ? entry_res : status_res;
        push.res1 = status_res;
        if (item_vld_reg)
        begin
            push.num = 2'({1'b0, emit} + {1'b0, eom_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            pos_reg      <= '0;
            cnt_reg      <= '0;
            seen_reg     <= '0;
            ebi_reg      <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            item_vld_reg <= take;
            if (item_vld_reg)
            begin
                pos_reg  <= pos_next;
                cnt_reg  <= cnt_next;
                seen_reg <= seen_next;
                ebi_reg  <= ebi_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= data_byte;
            eom_reg  <= end_of_message;
        end
        if (item_vld_reg)
        begin
            hdr_reg <= hdr_next;
            ent_reg <= ent_next;
        end
    end

endmodule

### hw/rtl/rtd_result_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results per cycle and hands out
// one per transfer.
// ----------------------------------------------------------------------------
module rtd_result_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rtd_pkg::rtd_push_t                push,
    input  logic                              pop,
    output rtd_pkg::rtd_result_t              head,
    output logic                              not_empty,
    output logic [rtd_pkg::FIFO_CNT_W-1:0]    level
);
    import rtd_pkg::*;

    rtd_result_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + FIFO_PTR_W'(push.num);
    assign cnt_next     = cnt_reg + FIFO_CNT_W'(push.num) - FIFO_CNT_W'(pop);
    assign head         = mem_reg[rd_ptr_reg];
    assign not_empty    = cnt_reg != '0;
    assign level        = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

endmodule
